[hdl/assert_macros.svh]
// Assertion macros shared by the latency violation detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low
`define CLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define CLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    `CLD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hdl/cld_pkg.sv]
// Shared widths, codes and reset values of the latency violation detector
package cld_pkg;

    localparam int LAT_W   = 40;
    localparam int CNT_W   = 32;
    localparam int ROOT_W  = CNT_W / 2;
    localparam int DIV_W   = ROOT_W + 1;
    localparam int EV_W    = 2;
    localparam int CIDX_W  = 2;

    typedef logic [LAT_W-1:0]  t_lat;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DIV_W-1:0]  t_div;
    typedef logic [EV_W-1:0]   t_ev;
    typedef logic [CIDX_W-1:0] t_cidx;

    // Result kinds
    localparam t_ev EV_SAMPLE = 2'd0;
    localparam t_ev EV_PASS   = 2'd1;
    localparam t_ev EV_VIOL   = 2'd2;
    localparam t_ev EV_SKIP   = 2'd3;

    // Input operations
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes
    localparam t_cidx CFG_BASE   = 2'd0;
    localparam t_cidx CFG_TARGET = 2'd1;
    localparam t_cidx CFG_ENABLE = 2'd2;

    localparam t_lat RST_BASE     = LAT_W'(100000000);
    localparam t_lat RST_TARGET   = LAT_W'(5000000);
    localparam t_lat FALLBACK_INT = LAT_W'(1000);

endpackage

[hdl/codel_latency_violation_detector_core.sv]
// Top level of the CoDel-style latency violation detector
//
//  channel  | direction | transfer            | contents
//  ---------+-----------+---------------------+-------------------------------------
//  s_axis   | in        | tvalid & tready     | tuser: operation, tdata: latency
//  m_axis   | out       | tvalid & tready     | tuser: event_res, tdata: results
//  cfg      | in        | valid & ready       | register index and 40-bit data
//
// Samples and non-violating ticks give a registered result in the cycle after the transaction
// and a new item is taken every cycle while the output drains.
// A violating tick passes through the states START, SQRT, DIV and OUT: the root
// takes two radicand bits a cycle, the divide one quotient bit a cycle.
// Synchronous active-low reset; configuration is always ready.
// A stalled output holds the result and blocks further input transactions.
`include "assert_macros.svh"

module codel_latency_violation_detector_core
    import cld_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [LAT_W-1:0]       s_axis_tdata,  // [39:0] latency
    input  logic [0:0]             s_axis_tuser,  // [0] operation
    // master stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [2*LAT_W+CNT_W-1:0] m_axis_tdata, // [39:0] current_interval,
                                                   // [71:40] violations,
                                                   // [111:72] min_seen
    output logic [EV_W-1:0]        m_axis_tuser,  // [1:0] event_res
    // configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  t_cidx                  i_cfg_index,
    input  t_lat                   i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SQRT  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    t_lat       r_base, r_target;
    logic       r_enable;
    t_lat       r_min, n_min;
    logic       r_min_valid, n_min_valid;
    t_cnt       r_viol, n_viol;
    t_lat       r_interval, n_interval;
    t_lat       r_seen, n_seen;

    logic       r_m_valid, n_m_valid;
    t_ev        r_o_ev, n_o_ev;
    t_lat       r_o_int, n_o_int;
    t_cnt       r_o_viol, n_o_viol;
    t_lat       r_o_seen, n_o_seen;

    logic       s_fire, out_free;
    logic       sqrt_start, sqrt_done, div_done;
    t_div       sqrt_root;
    t_lat       quot;
    t_lat       lat_in;

    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign lat_in        = s_axis_tdata;
    assign sqrt_start    = (r_state == S_START);
    assign o_cfg_ready   = 1'b1;

    // Rounded square root of the violation count
    cld_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_viol),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // base_interval / rounded root
    cld_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_done),
        .i_dividend (r_base),
        .i_divisor  (sqrt_root),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Control and result sequencing
    always_comb begin
        n_state     = r_state;
        n_min       = r_min;
        n_min_valid = r_min_valid;
        n_viol      = r_viol;
        n_interval  = r_interval;
        n_seen      = r_seen;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_o_ev      = r_o_ev;
        n_o_int     = r_o_int;
        n_o_viol    = r_o_viol;
        n_o_seen    = r_o_seen;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_m_valid = 1'b1;
                    n_o_int   = r_interval;
                    n_o_viol  = r_viol;
                    if (s_axis_tuser[0] == OP_SAMPLE) begin
                        if (!r_min_valid || (lat_in < r_min)) begin
                            n_min = lat_in;
                        end
                        n_min_valid = 1'b1;
                        n_o_ev      = EV_SAMPLE;
                        n_o_seen    = (!r_min_valid || (lat_in < r_min)) ? lat_in : r_min;
                    end else if (!r_min_valid) begin
                        n_o_ev   = EV_SKIP;
                        n_o_seen = '0;
                    end else begin
                        n_min       = '0;
                        n_min_valid = 1'b0;
                        n_o_seen    = r_min;
                        if (!r_enable) begin
                            n_o_ev = EV_SKIP;
                        end else if (r_min > r_target) begin
                            // violation: result waits for root and divide
                            n_m_valid = r_m_valid && !m_axis_tready;
                            n_seen    = r_min;
                            n_viol    = (r_viol == '1) ? r_viol : r_viol + 1'b1;
                            n_state   = S_START;
                        end else begin
                            n_viol     = '0;
                            n_interval = r_base;
                            n_o_ev     = EV_PASS;
                            n_o_int    = r_base;
                            n_o_viol   = '0;
                        end
                    end
                end
            end
            S_START: begin
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_interval = (quot == '0) ? FALLBACK_INT : quot;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_o_ev    = EV_VIOL;
                    n_o_int   = r_interval;
                    n_o_viol  = r_viol;
                    n_o_seen  = r_seen;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= RST_BASE;
            r_target    <= RST_TARGET;
            r_enable    <= 1'b1;
            r_min       <= '0;
            r_min_valid <= 1'b0;
            r_viol      <= '0;
            r_interval  <= RST_BASE;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_min       <= n_min;
            r_min_valid <= n_min_valid;
            r_viol      <= n_viol;
            r_interval  <= n_interval;
            r_m_valid   <= n_m_valid;
            // configuration writes; unknown indexes are dropped
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE:   r_base   <= i_cfg_data;
                    CFG_TARGET: r_target <= i_cfg_data;
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        r_seen   <= n_seen;
        r_o_ev   <= n_o_ev;
        r_o_int  <= n_o_int;
        r_o_viol <= n_o_viol;
        r_o_seen <= n_o_seen;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_o_ev;
    assign m_axis_tdata  = {r_o_seen, r_o_viol, r_o_int};

    // Checks
    `CLD_ASSERT(a_busy_blocks_input, (r_state != S_IDLE) |-> !s_axis_tready,
        "input taken while a tick is in progress")
    `CLD_ASSERT(a_viol_count_nonzero,
        (m_axis_tvalid && (m_axis_tuser == EV_VIOL)) |-> (m_axis_tdata[71:40] != '0),
        "violation reported with zero count")
    `CLD_ASSERT(a_viol_interval_nonzero,
        (m_axis_tvalid && (m_axis_tuser == EV_VIOL)) |-> (m_axis_tdata[39:0] != '0),
        "violation reported with zero interval")
    `CLD_ASSERT_NEXT(a_div_follows_sqrt, sqrt_done, (r_state == S_DIV),
        "divide not started after square root")

endmodule

[hdl/cld_isqrt.sv]
// Digit-serial square root, two radicand bits per cycle, rounded to nearest
module cld_isqrt
    import cld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cnt i_radicand,
    output logic o_done,
    output t_div o_root
);

    localparam int STEPS = CNT_W / 2;
    localparam int STEP_W = $clog2(STEPS);
    localparam int REM_W = ROOT_W + 4;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_step, n_step;
    t_cnt                r_rad, n_rad;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    t_div                r_res, n_res;

    logic [REM_W-1:0]    rem_sh, trial, rem_nx;
    logic [ROOT_W-1:0]   root_nx;
    logic                ge;

    // One digit step: bring down two bits, trial subtract 4r+1
    always_comb begin
        rem_sh  = {r_rem[REM_W-3:0], r_rad[CNT_W-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        ge      = (rem_sh >= trial);
        rem_nx  = ge ? (rem_sh - trial) : rem_sh;
        root_nx = {r_root[ROOT_W-2:0], ge};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_res  = r_res;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad  = {r_rad[CNT_W-3:0], 2'b00};
            n_rem  = rem_nx;
            n_root = root_nx;
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(STEPS - 1)) begin
                // remainder above root means sqrt is at least root + 0.5
                n_busy = 1'b0;
                n_done = 1'b1;
                n_res  = {1'b0, root_nx} + DIV_W'(rem_nx > REM_W'(root_nx));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_res  <= n_res;
    end

    assign o_done = r_done;
    assign o_root = r_res;

endmodule

[hdl/cld_div.sv]
// Restoring divider, one quotient bit per cycle
module cld_div
    import cld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_lat i_dividend,
    input  t_div i_divisor,
    output logic o_done,
    output t_lat o_quot
);

    localparam int STEP_W = $clog2(LAT_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    t_lat              r_num, n_num;
    t_div              r_rem, n_rem;
    t_div              r_den, n_den;

    logic [DIV_W:0]    rem_sh, rem_sub;
    logic              ge;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        rem_sh  = {r_rem, r_num[LAT_W-1]};
        ge      = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_num  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_num  = {r_num[LAT_W-2:0], ge};
            n_rem  = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(LAT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    // Dividend register holds the quotient once all bits are shifted through
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule
